FILE: hw/rtl/reno_pkg.sv
package reno_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MSS_W   = 16;
   localparam int unsigned CNT_W   = $clog2(DATA_W);

   localparam logic [MSS_W-1:0]  MSS_RESET    = 16'd1024;
   localparam logic [DATA_W-1:0] THRESH_RESET = 32'd65536;
   localparam logic [1:0]        DUP_LIMIT    = 2'd3;

   // configuration register indexes
   localparam logic CSR_SEGMENT_SIZE      = 1'b0;
   localparam logic CSR_INITIAL_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      REQ_ACK     = 2'd0,
      REQ_TIMEOUT = 2'd1,
      REQ_RESTART = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_NEW   = 2'd0,
      KIND_DUP   = 2'd1,
      KIND_STALE = 2'd2,
      KIND_NONE  = 2'd3
   } ack_kind_type;

   typedef enum logic [1:0] {
      PH_SLOW  = 2'd0,
      PH_AVOID = 2'd1,
      PH_RECOV = 2'd2
   } phase_type;

   // divider status as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

FILE: hw/rtl/reno_req_if.sv
interface reno_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] ack_number;
   logic [31:0] peer_window;

   modport source (output valid, req_type, ack_number, peer_window, input ready);
   modport sink (input valid, req_type, ack_number, peer_window, output ready);
endinterface

FILE: hw/rtl/reno_rsp_if.sv
interface reno_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  ack_kind;
   logic [31:0] congestion_window;
   logic [31:0] slow_start_threshold;
   logic [1:0]  phase;
   logic [31:0] send_window;
   logic        retransmit;

   modport source (output valid, ack_kind, congestion_window, slow_start_threshold, phase,
                   send_window, retransmit, input ready);
   modport sink (input valid, ack_kind, congestion_window, slow_start_threshold, phase,
                 send_window, retransmit, output ready);
endinterface

FILE: hw/rtl/reno_div.sv
module reno_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [reno_pkg::DATA_W-1:0]   dividend,
   input  logic [reno_pkg::DATA_W-1:0]   divisor,
   output logic [reno_pkg::DATA_W-1:0]   quotient,
   output reno_pkg::div_sts_type         sts
);
   import reno_pkg::*;

   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   rem_sub;
   logic              fits;

   // one quotient bit per cycle; quotient bits shift in behind the dividend
   always_comb begin
      rem_sh   = {rem_ff, shift_ff[DATA_W-1]};
      rem_sub  = rem_sh - {1'b0, dsr_ff};
      fits     = rem_sh >= {1'b0, dsr_ff};
      shift_in = shift_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         dsr_in   = divisor;
         rem_in   = '0;
         cnt_in   = CNT_W'(DATA_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[DATA_W-2:0], fits};
         rem_in   = fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      dsr_ff   <= dsr_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign quotient = shift_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

FILE: hw/rtl/reno_congestion_window.sv
// Reno congestion window for one sender. Each request (ACK, retransmission timeout or
// restart) gives exactly one response with the ACK class, the congestion window, the
// slow start threshold, the phase, the usable send window and a retransmit flag. One
// request is processed at a time, and a new ACK in congestion avoidance also runs the
// bit-serial divider, which forms mss*mss/cwnd one quotient bit per cycle. A finished
// response sits in an output register, so the next request is taken while it waits.
// Window growth saturates at all ones; ACK numbers compare as plain unsigned values.
module reno_congestion_window (
   input  logic                        clock,
   input  logic                        reset,
   reno_req_if.sink                    req_ch,
   reno_rsp_if.source                  rsp_ch,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [reno_pkg::DATA_W-1:0] csr_wdata
);
   import reno_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_GROW, S_DIVGO, S_DIVWAIT, S_ADDQ, S_DONE
   } state_type;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? '1 : s[DATA_W-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [MSS_W-1:0]  mss_ff, mss_in;
   logic [DATA_W-1:0] init_thresh_ff, init_thresh_in;
   logic [DATA_W-1:0] last_acked_ff, last_acked_in;
   logic [DATA_W-1:0] peer_ff, peer_in;
   logic [DATA_W-1:0] cwnd_ff, cwnd_in;
   logic [DATA_W-1:0] ssth_ff, ssth_in;
   phase_type         phase_ff, phase_in;
   logic [1:0]        dup_ff, dup_in;
   logic [1:0]        req_type_ff, req_type_in;
   logic [DATA_W-1:0] ack_ff, ack_in;
   logic [DATA_W-1:0] pw_ff, pw_in;
   ack_kind_type      kind_ff, kind_in;
   logic              rexmit_ff, rexmit_in;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ack_kind_type      rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_cwnd_ff, rsp_cwnd_in;
   logic [DATA_W-1:0] rsp_ssth_ff, rsp_ssth_in;
   phase_type         rsp_phase_ff, rsp_phase_in;
   logic [DATA_W-1:0] rsp_sw_ff, rsp_sw_in;
   logic              rsp_rexmit_ff, rsp_rexmit_in;

   logic [DATA_W-1:0] mss_ext;
   logic [DATA_W-1:0] mss3;
   logic [DATA_W-1:0] half_cwnd;
   logic [DATA_W-1:0] avoid_cwnd;
   logic [DATA_W-1:0] sw_min;
   logic [1:0]        dup_next;
   logic              accept;
   logic              out_free;
   logic              div_start;
   logic [DATA_W-1:0] div_quot;
   div_sts_type       div_sts;

   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign mss_ext   = DATA_W'(mss_ff);
   assign mss3      = DATA_W'({2'b00, mss_ff} + {1'b0, mss_ff, 1'b0});
   assign half_cwnd = {1'b0, cwnd_ff[DATA_W-1:1]};
   assign avoid_cwnd = (cwnd_ff == '0) ? mss_ext : cwnd_ff;
   assign dup_next  = dup_ff + 1'b1;
   assign sw_min    = (peer_ff < cwnd_ff) ? peer_ff : cwnd_ff;
   assign div_start = (state_ff == S_DIVGO);

   reno_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (cwnd_ff),
      .quotient (div_quot),
      .sts      (div_sts)
   );

   always_comb begin
      state_in       = state_ff;
      mss_in         = mss_ff;
      init_thresh_in = init_thresh_ff;
      last_acked_in  = last_acked_ff;
      peer_in        = peer_ff;
      cwnd_in        = cwnd_ff;
      ssth_in        = ssth_ff;
      phase_in       = phase_ff;
      dup_in         = dup_ff;
      req_type_in    = req_type_ff;
      ack_in         = ack_ff;
      pw_in          = pw_ff;
      kind_in        = kind_ff;
      rexmit_in      = rexmit_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_cwnd_in    = rsp_cwnd_ff;
      rsp_ssth_in    = rsp_ssth_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_sw_in      = rsp_sw_ff;
      rsp_rexmit_in  = rsp_rexmit_ff;

      // take configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_SEGMENT_SIZE:      mss_in = csr_wdata[MSS_W-1:0];
            CSR_INITIAL_THRESHOLD: init_thresh_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the response once it is taken
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_type_in = req_ch.req_type;
               ack_in      = req_ch.ack_number;
               pw_in       = req_ch.peer_window;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            kind_in   = KIND_NONE;
            rexmit_in = 1'b0;
            state_in  = S_DONE;
            case (req_type_ff)
               REQ_ACK: begin
                  peer_in = pw_ff;
                  if (ack_ff == last_acked_ff) begin
                     kind_in = KIND_DUP;
                     if (phase_ff == PH_RECOV) begin
                        cwnd_in   = sat_add(cwnd_ff, mss_ext);
                        rexmit_in = 1'b1;
                     end else begin
                        dup_in = dup_next;
                        if (dup_next == DUP_LIMIT) begin
                           ssth_in   = half_cwnd;
                           cwnd_in   = sat_add(half_cwnd, mss3);
                           phase_in  = PH_RECOV;
                           rexmit_in = 1'b1;
                        end
                     end
                  end else if (ack_ff > last_acked_ff) begin
                     kind_in       = KIND_NEW;
                     last_acked_in = ack_ff;
                     dup_in        = '0;
                     case (phase_ff)
                        PH_SLOW: begin
                           cwnd_in  = sat_add(cwnd_ff, mss_ext);
                           state_in = S_GROW;
                        end
                        PH_AVOID: begin
                           cwnd_in = avoid_cwnd;
                           prod_in = {16'd0, mss_ff} * {16'd0, mss_ff};
                           if (avoid_cwnd != '0) state_in = S_DIVGO;
                        end
                        PH_RECOV: begin
                           cwnd_in  = ssth_ff;
                           phase_in = PH_AVOID;
                        end
                        default: ;
                     endcase
                  end else begin
                     kind_in = KIND_STALE;
                  end
               end
               REQ_TIMEOUT: begin
                  ssth_in  = half_cwnd;
                  cwnd_in  = mss_ext;
                  dup_in   = '0;
                  phase_in = PH_SLOW;
               end
               REQ_RESTART: begin
                  last_acked_in = '0;
                  peer_in       = '0;
                  cwnd_in       = mss_ext;
                  ssth_in       = init_thresh_ff;
                  phase_in      = PH_SLOW;
                  dup_in        = '0;
               end
               default: ;
            endcase
         end
         S_GROW: begin
            if (cwnd_ff > ssth_ff) phase_in = PH_AVOID;
            state_in = S_DONE;
         end
         S_DIVGO: state_in = S_DIVWAIT;
         S_DIVWAIT: begin
            if (div_sts.done) state_in = S_ADDQ;
         end
         S_ADDQ: begin
            cwnd_in  = sat_add(cwnd_ff, div_quot);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_cwnd_in   = cwnd_ff;
               rsp_ssth_in   = ssth_ff;
               rsp_phase_in  = phase_ff;
               rsp_sw_in     = (sw_min == '0) ? DATA_W'(1) : sw_min;
               rsp_rexmit_in = rexmit_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         mss_ff         <= MSS_RESET;
         init_thresh_ff <= THRESH_RESET;
         last_acked_ff  <= '0;
         peer_ff        <= '0;
         cwnd_ff        <= DATA_W'(MSS_RESET);
         ssth_ff        <= THRESH_RESET;
         phase_ff       <= PH_SLOW;
         dup_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         mss_ff         <= mss_in;
         init_thresh_ff <= init_thresh_in;
         last_acked_ff  <= last_acked_in;
         peer_ff        <= peer_in;
         cwnd_ff        <= cwnd_in;
         ssth_ff        <= ssth_in;
         phase_ff       <= phase_in;
         dup_ff         <= dup_in;
      end
      req_type_ff   <= req_type_in;
      ack_ff        <= ack_in;
      pw_ff         <= pw_in;
      kind_ff       <= kind_in;
      rexmit_ff     <= rexmit_in;
      prod_ff       <= prod_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_cwnd_ff   <= rsp_cwnd_in;
      rsp_ssth_ff   <= rsp_ssth_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_rexmit_ff <= rsp_rexmit_in;
   end

   assign req_ch.ready                = (state_ff == S_IDLE);
   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.ack_kind             = rsp_kind_ff;
   assign rsp_ch.congestion_window    = rsp_cwnd_ff;
   assign rsp_ch.slow_start_threshold = rsp_ssth_ff;
   assign rsp_ch.phase                = rsp_phase_ff;
   assign rsp_ch.send_window          = rsp_sw_ff;
   assign rsp_ch.retransmit           = rsp_rexmit_ff;

`ifndef SYNTHESIS
   // only a duplicate ACK may ask for a resend
   a_rexmit_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.retransmit |-> rsp_ch.ack_kind == KIND_DUP)
      else $error("retransmit on a response that is not a duplicate ACK");

   // one request in flight: a transfer closes the input until its result is out
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken while another is in progress");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == S_DIVWAIT)
      else $error("divider finished outside its wait state");

   // the send window is never zero
   a_sw_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.send_window != '0)
      else $error("zero send window");
`endif

endmodule

FILE: sim/reno_congestion_window_tb.sv
module reno_congestion_window_tb;
   import reno_pkg::*;

   localparam logic [1:0]  REQ_UNUSED      = 2'd3;
   localparam logic [31:0] WORD_MAX        = 32'hFFFF_FFFF;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned SETTLE_CYCLES   = 60;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned RECOVERY_DUPS   = 40;
   localparam int unsigned REPORT_LIMIT    = 40;

   typedef struct {
      ack_kind_type kind;
      logic [31:0]  cwnd;
      logic [31:0]  ssthresh;
      phase_type    phase;
      logic [31:0]  send_win;
      logic         retransmit;
   } window_result_type;

   // Own copy of the sender's window state, advanced once per accepted request
   class window_tracker;
      logic [15:0]  mss;
      logic [31:0]  init_thresh;
      logic [31:0]  last_ack;
      logic [31:0]  peer_win;
      logic [31:0]  cwnd;
      logic [31:0]  ssthresh;
      phase_type    phase;
      logic [1:0]   dups;
      window_result_type expected_windows[$];
      int unsigned  failures;

      function new();
         mss         = MSS_RESET;
         init_thresh = THRESH_RESET;
         last_ack    = '0;
         peer_win    = '0;
         cwnd        = 32'(MSS_RESET);
         ssthresh    = THRESH_RESET;
         phase       = PH_SLOW;
         dups        = '0;
         failures    = 0;
      endfunction

      function void write_register(logic index, logic [31:0] value);
         if (index == CSR_SEGMENT_SIZE)
            mss = value[15:0];
         else
            init_thresh = value;
      endfunction

      // clamp every window increase at all ones
      function logic [31:0] add_clamped(logic [31:0] base, logic [63:0] delta);
         logic [63:0] sum;
         sum = {32'd0, base} + delta;
         return (sum > {32'd0, WORD_MAX}) ? WORD_MAX : sum[31:0];
      endfunction

      function void predict_request(logic [1:0] kind, logic [31:0] ack, logic [31:0] window);
         window_result_type want;
         logic [31:0]  usable;
         want.kind       = KIND_NONE;
         want.retransmit = 1'b0;
         case (kind)
            REQ_ACK: begin
               peer_win = window;
               if (ack == last_ack) begin
                  want.kind = KIND_DUP;
                  if (phase == PH_RECOV) begin
                     cwnd = add_clamped(cwnd, 64'(mss));
                     want.retransmit = 1'b1;
                  end else begin
                     // third duplicate: halve, inflate by three segments, recover
                     dups = dups + 2'd1;
                     if (dups == DUP_LIMIT) begin
                        ssthresh = cwnd >> 1;
                        cwnd = add_clamped(ssthresh, 64'(DUP_LIMIT) * 64'(mss));
                        phase = PH_RECOV;
                        want.retransmit = 1'b1;
                     end
                  end
               end else if (ack > last_ack) begin
                  want.kind = KIND_NEW;
                  last_ack = ack;
                  dups = '0;
                  case (phase)
                     PH_SLOW: begin
                        cwnd = add_clamped(cwnd, 64'(mss));
                        if (cwnd > ssthresh)
                           phase = PH_AVOID;
                     end
                     PH_AVOID: begin
                        if (cwnd == '0)
                           cwnd = 32'(mss);
                        if (cwnd != '0)
                           cwnd = add_clamped(cwnd, (64'(mss) * 64'(mss)) / 64'(cwnd));
                     end
                     PH_RECOV: begin
                        cwnd = ssthresh;
                        phase = PH_AVOID;
                     end
                     default: ;
                  endcase
               end else begin
                  want.kind = KIND_STALE;
               end
            end
            REQ_TIMEOUT: begin
               ssthresh = cwnd >> 1;
               cwnd = 32'(mss);
               dups = '0;
               phase = PH_SLOW;
            end
            REQ_RESTART: begin
               last_ack = '0;
               peer_win = '0;
               cwnd = 32'(mss);
               ssthresh = init_thresh;
               phase = PH_SLOW;
               dups = '0;
            end
            default: ;
         endcase
         usable = (peer_win < cwnd) ? peer_win : cwnd;
         if (usable == '0)
            usable = 32'd1;
         want.cwnd     = cwnd;
         want.ssthresh = ssthresh;
         want.phase    = phase;
         want.send_win = usable;
         expected_windows.push_back(want);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_response(window_result_type got);
         window_result_type want;
         if (expected_windows.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $error("response transfer with no request outstanding");
            return;
         end
         want = expected_windows.pop_front();
         compare_field("ack_kind", want.kind, got.kind);
         compare_field("congestion_window", want.cwnd, got.cwnd);
         compare_field("slow_start_threshold", want.ssthresh, got.ssthresh);
         compare_field("phase", want.phase, got.phase);
         compare_field("send_window", want.send_win, got.send_win);
         compare_field("retransmit", want.retransmit, got.retransmit);
      endfunction

      function int unsigned pending();
         return expected_windows.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic                csr_index;
   logic [DATA_W-1:0]   csr_wdata;

   reno_req_if req_if();
   reno_rsp_if rsp_if();

   window_tracker tracker = new();
   int unsigned   burst_left;
   int unsigned   requests_sent;
   logic [31:0]   acked_so_far;
   bit            hold_off_request;

   reno_congestion_window dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] pick_peer_window();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return WORD_MAX;
         2, 3: return $urandom;
         default: return $urandom_range(200000, 1);
      endcase
   endfunction

   // Offer one request in bursts with random gaps; predict it on transfer
   task automatic send_request(input logic [1:0] kind, input logic [31:0] ack,
                               input logic [31:0] window);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                                  : $urandom_range(24, 1);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.ack_number  <= ack;
      req_if.peer_window <= window;
      // hold the request until the block takes it
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.predict_request(kind, ack, window);
      if (kind == REQ_RESTART)
         acked_so_far = '0;
      else if (kind == REQ_ACK && ack > acked_so_far)
         acked_so_far = ack;
      if (kind != REQ_UNUSED)
         requests_sent++;
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] segment, input logic [31:0] threshold);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEGMENT_SIZE;
      csr_wdata <= {16'd0, segment};
      @(posedge clock);
      tracker.write_register(CSR_SEGMENT_SIZE, {16'd0, segment});
      csr_index <= CSR_INITIAL_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      tracker.write_register(CSR_INITIAL_THRESHOLD, threshold);
      csr_we <= 1'b0;
   endtask

   task automatic drive_directed();
      // duplicates of the reset ack number up to fast retransmit, then one in recovery
      send_request(REQ_ACK, 32'd0, WORD_MAX);
      send_request(REQ_ACK, 32'd0, 32'd0);
      send_request(REQ_ACK, 32'd0, $urandom);
      send_request(REQ_ACK, 32'd0, $urandom);
      // highest ack number ends recovery, then stale and duplicate in avoidance
      send_request(REQ_ACK, WORD_MAX, WORD_MAX);
      send_request(REQ_ACK, 32'd5, $urandom);
      send_request(REQ_ACK, WORD_MAX, $urandom);
      send_request(REQ_TIMEOUT, $urandom, $urandom);
      send_request(REQ_UNUSED, $urandom, $urandom);
      send_request(REQ_RESTART, $urandom, $urandom);
      send_request(REQ_ACK, 32'd1000, 32'd500);
      // zero peer window floors the send window at one
      send_request(REQ_ACK, 32'd2000, 32'd0);
      wait_for_results();

      // zero segment size: no growth, avoidance entered with a zero window
      set_registers(16'd0, 32'd1);
      send_request(REQ_RESTART, $urandom, $urandom);
      send_request(REQ_TIMEOUT, $urandom, $urandom);
      send_request(REQ_ACK, 32'd1, pick_peer_window());
      repeat (3) send_request(REQ_ACK, 32'd1, pick_peer_window());
      send_request(REQ_ACK, 32'd2, pick_peer_window());
      send_request(REQ_ACK, 32'd3, pick_peer_window());
      wait_for_results();
   endtask

   // Push the window high: a one-byte window in avoidance takes a huge
   // quotient, then a duplicate run in recovery adds a segment each
   task automatic drive_window_saturation();
      set_registers(16'd1, WORD_MAX);
      send_request(REQ_RESTART, $urandom, $urandom);
      send_request(REQ_ACK, 32'd1, pick_peer_window());
      repeat (3) send_request(REQ_ACK, 32'd1, pick_peer_window());
      wait_for_results();
      set_registers(16'hFFFF, WORD_MAX);
      send_request(REQ_ACK, 32'd2, pick_peer_window());
      send_request(REQ_ACK, 32'd3, pick_peer_window());
      repeat (3 + RECOVERY_DUPS) send_request(REQ_ACK, 32'd3, pick_peer_window());
      send_request(REQ_ACK, 32'd4, pick_peer_window());
      wait_for_results();
   endtask

   task automatic drive_random_sequence();
      int unsigned pick;
      int unsigned count;
      logic [31:0] step;
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
         // run of new ACKs, mostly small steps
         count = $urandom_range(8, 1);
         repeat (count) begin
            step = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(65536, 1);
            send_request(REQ_ACK,
                         (acked_so_far > WORD_MAX - step) ? WORD_MAX : acked_so_far + step,
                         pick_peer_window());
         end
      end else if (pick < 70) begin
         // duplicate run, often deep enough for fast retransmit, then a new ACK
         count = $urandom_range(6, 1);
         repeat (count) send_request(REQ_ACK, acked_so_far, pick_peer_window());
         step = $urandom_range(65536, 1);
         send_request(REQ_ACK,
                      (acked_so_far > WORD_MAX - step) ? WORD_MAX : acked_so_far + step,
                      pick_peer_window());
      end else if (pick < 80) begin
         // stale ACK below the last acknowledged number
         send_request(REQ_ACK,
                      (acked_so_far == '0) ? 32'd0 : $urandom_range(acked_so_far - 1, 0),
                      pick_peer_window());
      end else if (pick < 87) begin
         send_request(REQ_TIMEOUT, $urandom, $urandom);
      end else if (pick < 93) begin
         send_request(REQ_RESTART, $urandom, $urandom);
      end else if (pick < 97) begin
         send_request(REQ_UNUSED, $urandom, $urandom);
      end else begin
         send_request(2'($urandom_range(3, 0)), $urandom, $urandom);
      end
   endtask

   // Response side: check each transfer and stall on a pattern of its own
   initial begin : response_side
      bit           ready_level;
      int unsigned  level_left;
      int unsigned  hold_left;
      window_result_type seen;
      ready_level = 1'b0;
      level_left  = 0;
      hold_left   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen.kind       = ack_kind_type'(rsp_if.ack_kind);
            seen.cwnd       = rsp_if.congestion_window;
            seen.ssthresh   = rsp_if.slow_start_threshold;
            seen.phase      = phase_type'(rsp_if.phase);
            seen.send_win   = rsp_if.send_window;
            seen.retransmit = rsp_if.retransmit;
            tracker.check_response(seen);
         end
         // hold off for a long stretch once asked, else alternate ready runs
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (level_left == 0) begin
               ready_level = !ready_level;
               if (ready_level)
                  level_left = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 50)
                                                           : $urandom_range(30, 1);
               else
                  level_left = $urandom_range(5, 1);
            end
            level_left--;
            rsp_if.ready <= ready_level;
         end
      end
   end

   initial begin : stimulus
      logic [15:0] segment;
      logic [31:0] threshold;
      int unsigned phase_start;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SEGMENT_SIZE;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_ACK;
      req_if.ack_number  <= '0;
      req_if.peer_window <= '0;
      burst_left       = 0;
      requests_sent    = 0;
      acked_so_far     = '0;
      hold_off_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_directed();
      drive_window_saturation();

      // random traffic under a series of register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               segment   = MSS_RESET;
               threshold = THRESH_RESET;
            end
            1: begin
               segment   = 16'd1;
               threshold = 32'd1;
            end
            2: begin
               segment   = 16'hFFFF;
               threshold = WORD_MAX;
            end
            default: begin
               segment   = ($urandom_range(1, 0) == 0) ? $urandom_range(64, 1)
                                                       : $urandom_range(65535, 1);
               threshold = $urandom;
               if (threshold == '0)
                  threshold = 32'd1;
            end
         endcase
         set_registers(segment, threshold);
         if (p == 1)
            hold_off_request = 1'b1;
         phase_start = requests_sent;
         while (requests_sent - phase_start < ITEMS_PER_PHASE)
            drive_random_sequence();
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.failures++;
         $error("%0d predicted responses never arrived", tracker.pending());
      end
      if (tracker.failures == 0)
         $display("reno_congestion_window: match");
      else
         $display("reno_congestion_window: mismatch");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("reno_congestion_window: mismatch");
      $finish;
   end

endmodule
